// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL stamper unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hw/rtl/ctrs_pkg.sv -----
// ----------------------------------------------------------------------------
// ctrs_pkg
// Types and codes shared by the trace record stamper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctrs_pkg;

   typedef enum logic [1:0] {
      STATUS_QUEUED  = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_POPPED  = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_POP    = 1'b1;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_REMOTE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam int TIME_WIDTH = 48;
   localparam int SEQ_WIDTH  = 32;
   localparam int DROP_WIDTH = 32;
   localparam int BUS_WIDTH  = 8;

   typedef struct packed {
      logic                  func;
      logic                  is_tx;
      logic                  is_error;
      logic                  is_remote;
      logic [TIME_WIDTH-1:0] hw_timestamp_us;
      logic [TIME_WIDTH-1:0] arrival_us;
      logic [28:0]           can_id;
      logic [3:0]            data_length;
      logic [63:0]           payload;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [1:0]            record_kind;
      logic                  record_is_tx;
      logic [BUS_WIDTH-1:0]  record_bus;
      logic [TIME_WIDTH-1:0] offset_us;
      logic [SEQ_WIDTH-1:0]  sequence_number;
      logic [28:0]           record_can_id;
      logic [3:0]            record_length;
      logic [63:0]           record_payload;
      logic [DROP_WIDTH-1:0] dropped_total;
   } rsp_type;

   // One queued trace record.
   typedef struct packed {
      logic [1:0]            kind;
      logic                  is_tx;
      logic [BUS_WIDTH-1:0]  bus;
      logic [28:0]           can_id;
      logic [3:0]            length;
      logic [TIME_WIDTH-1:0] offset_us;
      logic [SEQ_WIDTH-1:0]  seq_num;
      logic [63:0]           payload;
   } record_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   function automatic rsp_type record_to_rsp(input record_type rec,
                                             input status_type st,
                                             input logic [DROP_WIDTH-1:0] drops);
      rsp_type r;
      r.status          = st;
      r.record_kind     = rec.kind;
      r.record_is_tx    = rec.is_tx;
      r.record_bus      = rec.bus;
      r.offset_us       = rec.offset_us;
      r.sequence_number = rec.seq_num;
      r.record_can_id   = rec.can_id;
      r.record_length   = rec.length;
      r.record_payload  = rec.payload;
      r.dropped_total   = drops;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/can_trace_record_stamper_unit.sv -----
// ----------------------------------------------------------------------------
// can_trace_record_stamper_unit
// Stamps CAN frame events into trace records and queues them; pops records.
// ----------------------------------------------------------------------------
// An accepted item passes the input register, then the result register, before its result is strobed.
// Throughput: one item per clock; busy is high only while reset is asserted.
// The input register and the result register bound the work between them:
// one offset add with compare, a queue write and a prefetched head read.
// Reset (synchronous) clears origin, sequence, drop total, queue pointers and the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

`include "assert_macros.svh"

module can_trace_record_stamper_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // command channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire ctrs_pkg::req_type              req_item,
   // bus number register
   input  wire logic                           csr_write_enable,
   input  wire logic [ctrs_pkg::BUS_WIDTH-1:0] csr_write_data,
   // result channel
   output logic                                rsp_strobe,
   output ctrs_pkg::rsp_type                   rsp_item
);
   import ctrs_pkg::*;

   // Input register: hold the accepted item while it is worked on.
   logic                  in_vld_ff;
   req_type               in_ff;
   logic [BUS_WIDTH-1:0]  bus_ff;
   logic [SEQ_WIDTH-1:0]  seq_ff;
   logic [SEQ_WIDTH-1:0]  seq_in;
   logic [DROP_WIDTH-1:0] drop_ff;
   logic [DROP_WIDTH-1:0] drop_in;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   fifo_ctl_type          fifo_ctl;
   fifo_stat_type         fifo_stat;
   record_type            new_rec;
   record_type            head_rec;
   logic [TIME_WIDTH-1:0] offset;
   logic [1:0]            kind;

   logic is_pop;
   logic do_push;
   logic do_drop;

   // Nothing inside can stall, so only reset holds off new items.
   assign busy = reset;

   assign is_pop  = (in_ff.func == FUNC_POP);
   assign do_push = in_vld_ff && !is_pop && !fifo_stat.full;
   assign do_drop = in_vld_ff && !is_pop && fifo_stat.full;

   assign fifo_ctl.push = do_push;
   assign fifo_ctl.pop  = in_vld_ff && is_pop && !fifo_stat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_ff <= req_item;
      end
   end

   // Bus number register; the user must write it only while idle, the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff <= '0;
      end else if (csr_write_enable) begin
         bus_ff <= csr_write_data;
      end
   end

   // Error wins over remote.
   always_comb begin
      if (in_ff.is_error) begin
         kind = KIND_ERROR;
      end else if (in_ff.is_remote) begin
         kind = KIND_REMOTE;
      end else begin
         kind = KIND_DATA;
      end
   end

   ctrs_offset_stamp u_stamp (
      .clock      (clock),
      .reset      (reset),
      .stamp_en   (do_push),
      .is_tx      (in_ff.is_tx),
      .hw_us      (in_ff.hw_timestamp_us),
      .arrival_us (in_ff.arrival_us),
      .offset_us  (offset)
   );

   // Advance the sequence only for queued records; it wraps.
   assign seq_in = do_push ? seq_ff + 1'b1 : seq_ff;

   // Saturate the drop total.
   assign drop_in = (do_drop && (drop_ff != '1)) ? drop_ff + 1'b1 : drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= '0;
         drop_ff <= '0;
      end else begin
         seq_ff  <= seq_in;
         drop_ff <= drop_in;
      end
   end

   always_comb begin
      new_rec.kind      = kind;
      new_rec.is_tx     = in_ff.is_tx;
      new_rec.bus       = bus_ff;
      new_rec.can_id    = in_ff.can_id;
      new_rec.length    = in_ff.data_length;
      new_rec.offset_us = offset;
      new_rec.seq_num   = seq_in;
      new_rec.payload   = in_ff.payload;
   end

   ctrs_record_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .ctl         (fifo_ctl),
      .wr_record   (new_rec),
      .stat        (fifo_stat),
      .head_record (head_rec)
   );

   // Build the result: echo a queued record, return the head on pop,
   // zero record fields on a drop or an empty pop.
   always_comb begin
      if (is_pop) begin
         if (fifo_stat.empty) begin
            rsp_in = record_to_rsp('0, STATUS_EMPTY, drop_in);
         end else begin
            rsp_in = record_to_rsp(head_rec, STATUS_POPPED, drop_in);
         end
      end else if (fifo_stat.full) begin
         rsp_in = record_to_rsp('0, STATUS_DROPPED, drop_in);
      end else begin
         rsp_in = record_to_rsp(new_rec, STATUS_QUEUED, drop_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // Every accepted item yields a strobed result through the input and result registers.
   `ASSERT_NEXT(a_item_yields_result, clock, reset, start && !busy, ##1 rsp_strobe)
   // The drop total never moves backwards.
   `ASSERT_NEXT(a_drop_monotonic, clock, reset, 1'b1, drop_ff >= $past(drop_ff))
   // The sequence counter moves only when a record is queued.
   `ASSERT_NEXT(a_seq_only_on_push, clock, reset, !do_push, $stable(seq_ff))

endmodule

`default_nettype wire

// ----- hw/rtl/ctrs_offset_stamp.sv -----
// ----------------------------------------------------------------------------
// ctrs_offset_stamp
// Trace time origin and per-frame offset calculation.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrs_offset_stamp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            stamp_en,
   input  wire logic                            is_tx,
   input  wire logic [ctrs_pkg::TIME_WIDTH-1:0] hw_us,
   input  wire logic [ctrs_pkg::TIME_WIDTH-1:0] arrival_us,
   output logic      [ctrs_pkg::TIME_WIDTH-1:0] offset_us
);
   import ctrs_pkg::*;

   localparam int BASE_WIDTH = TIME_WIDTH + 2;

   logic                  origin_valid_ff;
   logic [TIME_WIDTH-1:0] origin_hw_ff;
   // origin offset minus origin stamp, modulo 2^BASE_WIDTH
   logic [BASE_WIDTH-1:0] origin_base_ff;
   logic [BASE_WIDTH-1:0] origin_base_in;
   logic [BASE_WIDTH-1:0] sum;
   logic                  hw_present;
   logic                  latch_origin;

   assign hw_present     = (hw_us != '0);
   assign latch_origin   = stamp_en && !is_tx && hw_present && !origin_valid_ff;
   assign origin_base_in = {2'b00, arrival_us} - {2'b00, hw_us};
   assign sum            = origin_base_ff + {2'b00, hw_us};

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_valid_ff <= 1'b0;
      end else if (latch_origin) begin
         origin_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (latch_origin) begin
         origin_hw_ff   <= hw_us;
         origin_base_ff <= origin_base_in;
      end
   end

   always_comb begin
      if (is_tx || !hw_present || !origin_valid_ff || (hw_us < origin_hw_ff)) begin
         offset_us = arrival_us;
      end else if (sum[BASE_WIDTH-1:TIME_WIDTH] != '0) begin
         offset_us = '1;
      end else begin
         offset_us = sum[TIME_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ctrs_record_fifo.sv -----
// ----------------------------------------------------------------------------
// ctrs_record_fifo
// Record queue with a prefetched, registered head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrs_record_fifo #(
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrs_pkg::fifo_ctl_type   ctl,
   input  wire ctrs_pkg::record_type     wr_record,
   output ctrs_pkg::fifo_stat_type       stat,
   output ctrs_pkg::record_type          head_record
);
   import ctrs_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   record_type       mem [DEPTH];
   record_type       head_rec_ff;
   logic [IDX_W-1:0] head_ff;
   logic [IDX_W-1:0] head_in;
   logic [IDX_W-1:0] tail_ff;
   logic [IDX_W-1:0] tail_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign stat.empty  = (count_ff == '0);
   assign stat.full   = (count_ff == FULL_CNT);
   assign head_record = head_rec_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctl.push) begin
         tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Write the tail; prefetch the next head, forwarding a same-cycle write.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= wr_record;
      end
      if (ctl.push && (tail_ff == head_in)) begin
         head_rec_ff <= wr_record;
      end else begin
         head_rec_ff <= mem[head_in];
      end
   end

endmodule

`default_nettype wire
